// ===== rtl/ptdt_pkg.sv =====
// ============================================================================
// ptdt_pkg: shared definitions for the periodic task dispatch table
// Slot count, field widths, command and status codes, and the result record
// of the countdown unit.
// ============================================================================
package ptdt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = 32;
    localparam int DELAY_W   = 16;
    localparam int CMD_W     = 3;
    localparam int SLOT_F_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_CREATE  = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_SUSPEND = 3'd3,
        CMD_RESUME  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OCCUPIED = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic             due;
        logic             wr_en;
        logic [CNT_W-1:0] cd_next;
    } cnt_res_t;

endpackage

// ===== rtl/ptdt_req_if.sv =====
// ============================================================================
// ptdt_req_if: command channel
// Valid/ready channel that carries one command transaction per handshake.
// ============================================================================
interface ptdt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [4:0]  slot;
    logic [31:0] period;
    logic [15:0] first_delay;
    logic        start_ready;

    modport source (output valid, output cmd, output slot, output period,
                    output first_delay, output start_ready, input ready);
    modport sink   (input valid, input cmd, input slot, input period,
                    input first_delay, input start_ready, output ready);
endinterface

// ===== rtl/ptdt_rsp_if.sv =====
// ============================================================================
// ptdt_rsp_if: result channel
// Valid/ready channel that carries one result transaction per handshake.
// ============================================================================
interface ptdt_rsp_if;
    logic       valid;
    logic       ready;
    logic       due;
    logic [4:0] due_slot;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output due, output due_slot, output status,
                    output last, input ready);
    modport sink   (input valid, input due, input due_slot, input status,
                    input last, output ready);
endinterface

// ===== rtl/ptdt_ram.sv =====
// ============================================================================
// ptdt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module ptdt_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ptdt_count_unit.sv =====
// ============================================================================
// ptdt_count_unit: shared countdown unit
// Checks one slot's countdown for zero and forms its reload or decrement.
// ============================================================================
module ptdt_count_unit (
    input  logic                         active,
    input  logic [ptdt_pkg::CNT_W-1:0]   countdown,
    input  logic [ptdt_pkg::CNT_W-1:0]   period,
    output ptdt_pkg::cnt_res_t           res
);
    import ptdt_pkg::*;

    logic zero;

    assign zero = (countdown == '0);

    always_comb
    begin
        res.due     = active && zero;
        res.wr_en   = active;
        res.cd_next = zero ? period : (countdown - CNT_W'(1));
    end

endmodule

// ===== rtl/periodic_task_dispatch_table.sv =====
// ============================================================================
// periodic_task_dispatch_table: time-triggered task slot table
// Holds task slots with period and countdown and reports due tasks on a tick.
// ============================================================================
// Usage:
// Commands enter on the req channel; results leave on the rsp channel.
// Create, delete, suspend and resume give one result transaction with a
// status and last set. A tick gives one result per due slot, in ascending
// slot order, then a closing result with last set.
// A command's result is formed in S_CMD after its transaction is taken and
// waits there until the output register is free. A tick visits one slot per
// cycle through the shared countdown unit and the countdown and period RAMs
// while no due slot stalls; req.ready is low for the whole tick.
// When the receiver stalls, the output register holds its result and the
// walk waits at the next due slot until the register frees up.
// The block takes a new command while its last result still waits.
// Reset clears every valid and ready mark and drops any pending result;
// period and countdown RAM contents are only read for valid slots, and a
// create always rewrites both, so they need no clearing.
// ============================================================================
module periodic_task_dispatch_table (
    input  logic           clk,
    input  logic           rst_n,
    ptdt_req_if.sink       req,
    ptdt_rsp_if.source     rsp
);
    import ptdt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_WALK,
        S_FIN
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [NUM_SLOTS-1:0]  valid_reg, valid_next;
    logic [NUM_SLOTS-1:0]  ready_reg, ready_next;

    logic [CMD_W-1:0]      cmd_reg;
    logic [SLOT_F_W-1:0]   slot_reg;
    logic [CNT_W-1:0]      period_reg;
    logic [DELAY_W-1:0]    delay_reg;
    logic                  start_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  due_reg, due_next;
    logic [SLOT_F_W-1:0]   due_slot_reg, due_slot_next;
    status_t               status_reg, status_next;
    logic                  last_reg, last_next;

    logic                  accept;
    logic                  out_free;
    logic                  in_range;
    logic [SLOT_W-1:0]     slot_idx;
    status_t               cmd_status;
    logic                  act;
    logic                  stall;
    cnt_res_t              cnt;

    logic                  cd_we;
    logic [SLOT_W-1:0]     cd_waddr;
    logic [CNT_W-1:0]      cd_wdata;
    logic [CNT_W-1:0]      cd_rdata;
    logic                  per_we;
    logic [CNT_W-1:0]      per_rdata;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign in_range = ({1'b0, slot_reg} < (SLOT_F_W + 1)'(NUM_SLOTS));
    assign slot_idx = slot_reg[SLOT_W-1:0];
    assign act      = valid_reg[idx_reg] && ready_reg[idx_reg];
    assign stall    = cnt.due && !out_free;

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.due      = due_reg;
    assign rsp.due_slot = due_slot_reg;
    assign rsp.status   = status_reg;
    assign rsp.last     = last_reg;

    ptdt_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SLOTS), .ADDR_W(SLOT_W)) u_cd_ram (
        .clk   (clk),
        .we    (cd_we),
        .waddr (cd_waddr),
        .wdata (cd_wdata),
        .raddr (idx_next),
        .rdata (cd_rdata)
    );

    ptdt_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SLOTS), .ADDR_W(SLOT_W)) u_per_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (slot_idx),
        .wdata (period_reg),
        .raddr (idx_next),
        .rdata (per_rdata)
    );

    ptdt_count_unit u_count (
        .active    (act),
        .countdown (cd_rdata),
        .period    (per_rdata),
        .res       (cnt)
    );

    // Unused command codes answer OK before any range check.
    always_comb
    begin
        priority if (cmd_reg > CMD_RESUME)
        begin
            cmd_status = ST_OK;
        end
        else if (!in_range)
        begin
            cmd_status = ST_RANGE;
        end
        else if (cmd_reg == CMD_CREATE)
        begin
            cmd_status = valid_reg[slot_idx] ? ST_OCCUPIED : ST_OK;
        end
        else
        begin
            cmd_status = valid_reg[slot_idx] ? ST_OK : ST_EMPTY;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        due_next       = due_reg;
        due_slot_next  = due_slot_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        cd_we          = 1'b0;
        cd_waddr       = idx_reg;
        cd_wdata       = cnt.cd_next;
        per_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    state_next = (req.cmd == CMD_TICK) ? S_WALK : S_CMD;
                end
            end
            S_CMD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    due_next       = 1'b0;
                    due_slot_next  = '0;
                    status_next    = cmd_status;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                    if (cmd_status == ST_OK)
                    begin
                        unique case (cmd_reg)
                            CMD_CREATE:
                            begin
                                valid_next[slot_idx] = 1'b1;
                                ready_next[slot_idx] = start_reg;
                                cd_we    = 1'b1;
                                cd_waddr = slot_idx;
                                cd_wdata = CNT_W'(delay_reg);
                                per_we   = 1'b1;
                            end
                            CMD_DELETE:  valid_next[slot_idx] = 1'b0;
                            CMD_SUSPEND: ready_next[slot_idx] = 1'b0;
                            CMD_RESUME:  ready_next[slot_idx] = 1'b1;
                            default:     ;
                        endcase
                    end
                end
            end
            S_WALK:
            begin
                // A stalled due slot keeps its index, so the RAMs re-read it.
                if (!stall)
                begin
                    cd_we = cnt.wr_en;
                    if (cnt.due)
                    begin
                        out_valid_next = 1'b1;
                        due_next       = 1'b1;
                        due_slot_next  = SLOT_F_W'(idx_reg);
                        status_next    = ST_OK;
                        last_next      = 1'b0;
                    end
                    if (idx_reg == SLOT_W'(NUM_SLOTS - 1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    due_next       = 1'b0;
                    due_slot_next  = '0;
                    status_next    = ST_OK;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            ready_reg     <= '0;
            out_valid_reg <= 1'b0;
            due_reg       <= 1'b0;
            due_slot_reg  <= '0;
            status_reg    <= ST_OK;
            last_reg      <= 1'b0;
            cmd_reg       <= '0;
            slot_reg      <= '0;
            period_reg    <= '0;
            delay_reg     <= '0;
            start_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
            due_reg       <= due_next;
            due_slot_reg  <= due_slot_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
            if (accept)
            begin
                cmd_reg    <= req.cmd;
                slot_reg   <= req.slot;
                period_reg <= req.period;
                delay_reg  <= req.first_delay;
                start_reg  <= req.start_ready;
            end
        end
    end

endmodule

// ===== rtl/ptdt_checker.sv =====
// ============================================================================
// ptdt_checker: port-level checks for the periodic task dispatch table
// Watches the command and result channels and is bound to the top level.
// ============================================================================
module ptdt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       due,
    input logic [4:0] due_slot,
    input logic [1:0] status,
    input logic       last
);
    import ptdt_pkg::*;

    // Every command keeps the block busy in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command taken while the previous one was in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable({due, due_slot, status, last}))
        else $error("stalled result changed or was dropped");

    a_due_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && due |-> status == ST_OK && !last
                             && {1'b0, due_slot} < 6'(NUM_SLOTS))
        else $error("due result with bad status, last flag or slot");

    a_only_due_open: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> due)
        else $error("non-final result that reports no due task");

endmodule

bind periodic_task_dispatch_table ptdt_checker u_ptdt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .due       (rsp.due),
    .due_slot  (rsp.due_slot),
    .status    (rsp.status),
    .last      (rsp.last)
);

// ===== test/periodic_task_dispatch_table_tb.sv =====
// ============================================================================
// periodic_task_dispatch_table_tb: self-checking bench for the dispatch table
// Sends tick and slot commands on the req channel and scores every result on
// the rsp channel. Expected results come from a behavioral copy of the slot
// table that is updated as each command is accepted. Both channels idle at
// random, and the receiver holds off once for a long stretch.
// ============================================================================
module periodic_task_dispatch_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ptdt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
    localparam int RANDOM_ITEMS   = 105;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 30;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SLOT_F_W-1:0] slot;
        logic [CNT_W-1:0]    period;
        logic [DELAY_W-1:0]  first_delay;
        logic                start_ready;
    } command_t;

    typedef struct packed {
        logic                due;
        logic [SLOT_F_W-1:0] due_slot;
        status_t             status;
        logic                last;
    } dispatch_t;

    logic clk;
    logic rst_n;

    ptdt_req_if req_ch ();
    ptdt_rsp_if rsp_ch ();

    periodic_task_dispatch_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Behavioral copy of the slot table.
    logic             task_valid     [NUM_SLOTS];
    logic             task_runnable  [NUM_SLOTS];
    logic [CNT_W-1:0] task_period    [NUM_SLOTS];
    logic [CNT_W-1:0] task_countdown [NUM_SLOTS];

    command_t  command_q[$];
    dispatch_t dispatch_q[$];
    command_t  in_flight;

    int error_cnt      = 0;
    int accepted_items = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit long_hold_on   = 1'b0;
    bit rdy_next;
    int idle_cycles    = 0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic command_t make_cmd(logic [CMD_W-1:0] c, logic [SLOT_F_W-1:0] s,
                                          logic [CNT_W-1:0] p, logic [DELAY_W-1:0] d,
                                          logic r);
        command_t item;
        item.cmd         = c;
        item.slot        = s;
        item.period      = p;
        item.first_delay = d;
        item.start_ready = r;
        return item;
    endfunction

    function automatic void post_result(logic due, logic [SLOT_F_W-1:0] dslot,
                                        status_t st, logic last);
        dispatch_t res;
        res.due      = due;
        res.due_slot = dslot;
        res.status   = st;
        res.last     = last;
        dispatch_q.push_back(res);
    endfunction

    // Applies one accepted command to the table copy and queues its results.
    function automatic void run_scheduler(command_t item);
        int      s;
        status_t st;
        if (item.cmd == CMD_TICK)
        begin
            for (s = 0; s < NUM_SLOTS; s++)
            begin
                if (task_valid[s] && task_runnable[s])
                begin
                    if (task_countdown[s] == '0)
                    begin
                        post_result(1'b1, SLOT_F_W'(s), ST_OK, 1'b0);
                        task_countdown[s] = task_period[s];
                    end
                    else
                        task_countdown[s] = task_countdown[s] - 1'b1;
                end
            end
            post_result(1'b0, '0, ST_OK, 1'b1);
            return;
        end
        if (item.cmd > CMD_RESUME)
        begin
            post_result(1'b0, '0, ST_OK, 1'b1);
            return;
        end
        s = int'(item.slot);
        if (s >= NUM_SLOTS)
            st = ST_RANGE;
        else if (item.cmd == CMD_CREATE)
        begin
            if (task_valid[s])
                st = ST_OCCUPIED;
            else
            begin
                task_valid[s]     = 1'b1;
                task_runnable[s]  = item.start_ready;
                task_period[s]    = item.period;
                task_countdown[s] = CNT_W'(item.first_delay);
                st = ST_OK;
            end
        end
        else if (!task_valid[s])
            st = ST_EMPTY;
        else
        begin
            if (item.cmd == CMD_DELETE)
                task_valid[s] = 1'b0;
            else if (item.cmd == CMD_SUSPEND)
                task_runnable[s] = 1'b0;
            else
                task_runnable[s] = 1'b1;
            st = ST_OK;
        end
        post_result(1'b0, '0, st, 1'b1);
    endfunction

    function automatic command_t random_cmd();
        int               r;
        logic [CMD_W-1:0] c;
        logic [4:0]       s;
        logic [31:0]      p;
        logic [15:0]      d;
        r = $urandom_range(0, 99);
        if (r < 35)
            c = CMD_TICK;
        else if (r < 65)
            c = CMD_CREATE;
        else if (r < 75)
            c = CMD_DELETE;
        else if (r < 85)
            c = CMD_SUSPEND;
        else if (r < 95)
            c = CMD_RESUME;
        else
            c = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        s = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(NUM_SLOTS, 31))
                                        : 5'($urandom_range(0, NUM_SLOTS - 1));
        // Short periods and delays keep tasks coming due; full-width values
        // now and then exercise every bit of both fields.
        p = ($urandom_range(0, 4) == 0) ? 32'($urandom) : 32'($urandom_range(0, 6));
        d = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 6));
        return make_cmd(c, s, p, d, ($urandom_range(0, 4) != 0));
    endfunction

    // Stimulus and end of run.
    initial
    begin
        int i;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            task_valid[i]     = 1'b0;
            task_runnable[i]  = 1'b0;
            task_period[i]    = '0;
            task_countdown[i] = '0;
        end
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_TICK;
        req_ch.slot        = '0;
        req_ch.period      = '0;
        req_ch.first_delay = '0;
        req_ch.start_ready = 1'b0;
        rsp_ch.ready       = 1'b0;

        // Directed part: empty table, status cases, extremes, reload.
        command_q.push_back(make_cmd(CMD_TICK,    5'd0,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_CREATE,  5'd0,  32'd0, 16'd0, 1'b1));
        command_q.push_back(make_cmd(CMD_CREATE,  5'd0,  32'd5, 16'd5, 1'b1));
        command_q.push_back(make_cmd(CMD_CREATE,  5'd15, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        command_q.push_back(make_cmd(CMD_CREATE,  5'd16, 32'd1, 16'd1, 1'b1));
        command_q.push_back(make_cmd(CMD_DELETE,  5'd31, 32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_SUSPEND, 5'd20, 32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_RESUME,  5'd16, 32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_DELETE,  5'd5,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_SUSPEND, 5'd5,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_RESUME,  5'd5,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_CREATE,  5'd7,  32'd2, 16'd1, 1'b0));
        command_q.push_back(make_cmd(CMD_TICK,    5'd0,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_RESUME,  5'd7,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_CREATE,  5'd3,  32'hFFFF_FFFF, 16'd0, 1'b1));
        command_q.push_back(make_cmd(CMD_TICK,    5'd0,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_TICK,    5'd0,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_SUSPEND, 5'd0,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_TICK,    5'd0,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_DELETE,  5'd7,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_CREATE,  5'd7,  32'd1, 16'd0, 1'b1));
        command_q.push_back(make_cmd(CMD_TICK,    5'd0,  32'd0, 16'd0, 1'b0));
        command_q.push_back(make_cmd(CMD_UNUSED_FIRST,        5'd31, 32'hFFFF_FFFF,
                                     16'hFFFF, 1'b1));
        command_q.push_back(make_cmd(CMD_UNUSED_FIRST + 3'd1, 5'd2, 32'd9, 16'd9, 1'b0));
        command_q.push_back(make_cmd(CMD_UNUSED_LAST,         5'd0, 32'd0, 16'd0, 1'b1));

        for (i = 0; i < RANDOM_ITEMS; i++)
            command_q.push_back(random_cmd());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (command_q.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (dispatch_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_cnt == 0)
            $display("periodic_task_dispatch_table_tb: done, clean");
        else
            $display("periodic_task_dispatch_table_tb: done, errors");
        $finish;
    end

    // Driver: offers queued commands with random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                run_scheduler(in_flight);
                accepted_items <= accepted_items + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0 || command_q.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    in_flight = command_q.pop_front();
                    req_ch.cmd         <= in_flight.cmd;
                    req_ch.slot        <= in_flight.slot;
                    req_ch.period      <= in_flight.period;
                    req_ch.first_delay <= in_flight.first_delay;
                    req_ch.start_ready <= in_flight.start_ready;
                    req_ch.valid       <= 1'b1;
                    // During the long hold and one window later on, the
                    // sender pushes back to back.
                    if (long_hold_on || (accepted_items >= 70 && accepted_items < 100))
                        send_gap = 0;
                    else
                        send_gap = pick_gap();
                end
            end
        end
    end

    // Receiver: random stalls, one long hold, and one window with none.
    always @(posedge clk)
    begin
        if (!rst_n)
            rdy_next = 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rdy_next = 1'b0;
        end
        else if (!hold_done && accepted_items >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rdy_next  = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rdy_next = 1'b0;
        end
        else if (accepted_items >= 70 && accepted_items < 100)
            rdy_next = 1'b1;
        else
        begin
            stall_left = pick_gap();
            rdy_next   = (stall_left == 0);
        end
        rsp_ch.ready <= rdy_next;
        long_hold_on <= (hold_left > 0);
    end

    // Monitor: scores each result against the oldest prediction.
    always @(posedge clk)
    begin
        dispatch_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (dispatch_q.size() == 0)
            begin
                error_cnt++;
                $display("%0t: unexpected result due=%0b slot=%0d status=%0d last=%0b",
                         $realtime, rsp_ch.due, rsp_ch.due_slot, rsp_ch.status,
                         rsp_ch.last);
            end
            else
            begin
                want = dispatch_q.pop_front();
                if (rsp_ch.due !== want.due)
                begin
                    error_cnt++;
                    $display("%0t: due mismatch, expected %0b, actual %0b",
                             $realtime, want.due, rsp_ch.due);
                end
                if (rsp_ch.due_slot !== want.due_slot)
                begin
                    error_cnt++;
                    $display("%0t: due_slot mismatch, expected %0d, actual %0d",
                             $realtime, want.due_slot, rsp_ch.due_slot);
                end
                if (rsp_ch.status !== want.status)
                begin
                    error_cnt++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $realtime, want.status, rsp_ch.status);
                end
                if (rsp_ch.last !== want.last)
                begin
                    error_cnt++;
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $realtime, want.last, rsp_ch.last);
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves a transaction for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("periodic_task_dispatch_table_tb: done, errors");
                $finish;
            end
        end
    end

endmodule
